[hdl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window minimum core
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W      = 6;
  localparam int DATA_W     = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_min;
    logic                     last_result;
  } out_t;

endpackage

`default_nettype wire

[hdl/sliding_window_minimum_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_minimum_core
// minimum over the newest window_length samples of a stream, samples kept
// in a circular buffer memory and scanned one entry per cycle
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | swm_pkg::in_t  (sample, last)
//  out     | output    | out_valid / out_stall | swm_pkg::out_t (min, last)
//  cfg     | input     | cfg_valid / cfg_ready | window_length, 6 bits
//
//  a transaction with a result over n > 1 samples runs as: store, n - 1
//  buffer reads, a wait for the last read data, then loading the output;
//  over one sample it is store then output load, with no result only store.
//  synchronous active-low reset clears counters and control, not the buffer.
//  a stalled output holds the scan in its final cycle until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_minimum_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire swm_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output swm_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [swm_pkg::CFG_W-1:0]  cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic [swm_pkg::CNT_W-1:0]  MAX_CNT  = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
  localparam logic [swm_pkg::ADDR_W-1:0] LAST_ADR = swm_pkg::ADDR_W'(swm_pkg::MAX_WINDOW - 1);

  logic [swm_pkg::DATA_W-1:0] mem [swm_pkg::MAX_WINDOW];

  logic                             state_r, state_nxt;
  logic [swm_pkg::CFG_W-1:0]        wlen_r, wlen_nxt;
  logic [swm_pkg::CNT_W-1:0]        fill_r, fill_nxt;
  logic [swm_pkg::ADDR_W-1:0]       wp_r, wp_nxt;
  logic [swm_pkg::ADDR_W-1:0]       rd_r, rd_nxt;
  logic [swm_pkg::CNT_W-1:0]        iss_r, iss_nxt;
  logic                             rvld_r, rvld_nxt;
  logic signed [swm_pkg::DATA_W-1:0] best_r, best_nxt;
  logic                             last_r, last_nxt;
  logic [swm_pkg::DATA_W-1:0]       rdata_r;
  logic                             ovld_r, ovld_nxt;
  swm_pkg::out_t                    odata_r, odata_nxt;

  logic                             in_acc;
  logic                             rd_en;
  logic [swm_pkg::CNT_W-1:0]        k;
  logic [swm_pkg::CNT_W-1:0]        fill_inc;
  logic [swm_pkg::CNT_W-1:0]        n;
  logic                             produce;
  logic signed [swm_pkg::DATA_W-1:0] best_cmp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  always_comb begin
    // window above the buffer depth saturates
    if (swm_pkg::CNT_W'(wlen_r) > MAX_CNT) begin
      k = MAX_CNT;
    end else begin
      k = swm_pkg::CNT_W'(wlen_r);
    end
    fill_inc = (fill_r < MAX_CNT) ? fill_r + 1'b1 : fill_r;
    produce  = (k != '0) && ((fill_inc >= k) || in_data.last_sample);
    n        = (fill_inc >= k) ? k : fill_inc;
    rd_en    = (state_r == ST_SCAN) && (iss_r != '0);
    best_cmp = ($signed(rdata_r) < best_r) ? $signed(rdata_r) : best_r;
  end

  always_comb begin
    state_nxt = state_r;
    wlen_nxt  = wlen_r;
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    rd_nxt    = rd_r;
    iss_nxt   = iss_r;
    rvld_nxt  = 1'b0;
    best_nxt  = best_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && out_stall;
    odata_nxt = odata_r;

    if (cfg_valid && cfg_ready) begin
      wlen_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // the newest sample seeds the minimum, older ones come from the buffer
          best_nxt = in_data.sample;
          last_nxt = in_data.last_sample;
          rd_nxt   = (wp_r == '0) ? LAST_ADR : wp_r - 1'b1;
          iss_nxt  = n - 1'b1;
          if (in_data.last_sample) begin
            fill_nxt = '0;
            wp_nxt   = '0;
          end else begin
            fill_nxt = fill_inc;
            wp_nxt   = (wp_r == LAST_ADR) ? '0 : wp_r + 1'b1;
          end
          if (produce) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rvld_r) begin
          best_nxt = best_cmp;
        end
        if (rd_en) begin
          rd_nxt   = (rd_r == '0) ? LAST_ADR : rd_r - 1'b1;
          iss_nxt  = iss_r - 1'b1;
          rvld_nxt = 1'b1;
        end else if (!rvld_r && (!ovld_r || !out_stall)) begin
          ovld_nxt              = 1'b1;
          odata_nxt.window_min  = best_r;
          odata_nxt.last_result = last_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wlen_r  <= swm_pkg::CFG_W'(1);
      fill_r  <= '0;
      wp_r    <= '0;
      iss_r   <= '0;
      rvld_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      fill_r  <= fill_nxt;
      wp_r    <= wp_nxt;
      iss_r   <= iss_nxt;
      rvld_r  <= rvld_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    best_r  <= best_nxt;
    last_r  <= last_nxt;
    odata_r <= odata_nxt;
  end

  // sample buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wp_r] <= in_data.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_r];
    end
  end

endmodule

`default_nettype wire

[test/sliding_window_minimum_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_core_tb
// self-checking bench: a short table of hand-picked samples and window
// settings, then bursty random sequences over many window lengths, each
// result compared with an in-bench model of the windowed minimum or, for
// most table rows, with an expectation typed into the table

module sliding_window_minimum_core_tb;

  localparam int RAND_ITEMS = 950;
  localparam int DRAIN_CYC  = 40;
  localparam int CYC_LIMIT  = 600000;

  typedef struct {
    bit                        is_cfg;
    logic [swm_pkg::CFG_W-1:0] wlen;
    logic [31:0]               smp;
    bit                        lst;
    bit                        pin;
    bit                        pmade;
    logic [31:0]               pmin;
    bit                        plast;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  swm_pkg::in_t                in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  swm_pkg::out_t               out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [swm_pkg::CFG_W-1:0]   cfg_data = '0;

  // model state
  logic signed [swm_pkg::DATA_W-1:0] win_hist [swm_pkg::MAX_WINDOW];
  int                                win_fill;
  int                                win_wr;
  logic [swm_pkg::CFG_W-1:0]         win_len;

  swm_pkg::out_t min_q [$];
  int            fail_cnt = 0;
  int            cyc = 0;

  // typed-in expectation for the transaction being offered
  bit            pin_on = 1'b0;
  bit            pin_made = 1'b0;
  swm_pkg::out_t pin_res = '0;

  // receiver stall pattern
  int   stall_tick = 0;
  int   stall_mode = 0;
  int   run_left = 0;
  bit   run_lvl = 1'b0;
  bit   stall_lvl;

  dir_row_t dir_rows [26] = '{
    '{0, 6'd0,  32'h7fffffff, 0, 1, 1, 32'h7fffffff, 0},
    '{0, 6'd0,  32'h80000000, 1, 1, 1, 32'h80000000, 1},
    '{1, 6'd0,  32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'h5,        0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'hfffffffd, 1, 1, 0, 32'h0,        0},
    '{1, 6'd3,  32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'd10,       0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd4,        0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd4,        0, 1, 1, 32'd4,        0},
    '{0, 6'd0,  32'd9,        1, 1, 1, 32'd4,        1},
    '{0, 6'd0,  32'hffffffff, 0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd2,        1, 1, 1, 32'hffffffff, 1},
    '{1, 6'd32, 32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'h12345678, 0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'h87654321, 0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'h0,        1, 0, 0, 32'h0,        0},
    '{1, 6'd63, 32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'hfffffff9, 0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd100,      1, 1, 1, 32'hfffffff9, 1},
    '{1, 6'd4,  32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'd1,        0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd2,        0, 1, 0, 32'h0,        0},
    '{0, 6'd0,  32'd3,        0, 1, 0, 32'h0,        0},
    '{1, 6'd2,  32'h0,        0, 0, 0, 32'h0,        0},
    '{0, 6'd0,  32'd0,        0, 1, 1, 32'd0,        0},
    '{0, 6'd0,  32'd5,        1, 0, 0, 32'h0,        0}
  };

  sliding_window_minimum_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYC_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // store one sample and work out the windowed minimum it yields, if any
  function automatic void calc_window_min(input swm_pkg::in_t it, output bit made,
                                          output swm_pkg::out_t res);
    int                                k;
    int                                cnt;
    int                                idx;
    logic signed [swm_pkg::DATA_W-1:0] m;
    k = (win_len > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : int'(win_len);
    win_hist[win_wr] = it.sample;
    win_wr = (win_wr + 1) % swm_pkg::MAX_WINDOW;
    if (win_fill < swm_pkg::MAX_WINDOW) win_fill++;
    made = 1'b0;
    res = '0;
    cnt = 0;
    if (k != 0) begin
      if (win_fill >= k) cnt = k;
      else if (it.last_sample) cnt = win_fill;
    end
    if (cnt != 0) begin
      m = win_hist[(win_wr + swm_pkg::MAX_WINDOW - 1) % swm_pkg::MAX_WINDOW];
      for (int i = 1; i < cnt; i++) begin
        idx = (win_wr + 2 * swm_pkg::MAX_WINDOW - 1 - i) % swm_pkg::MAX_WINDOW;
        if (win_hist[idx] < m) m = win_hist[idx];
      end
      made = 1'b1;
      res.window_min = m;
      res.last_result = it.last_sample;
    end
    if (it.last_sample) begin
      win_fill = 0;
      win_wr = 0;
    end
  endfunction

  always @(posedge clk) begin : mon
    bit            made;
    swm_pkg::out_t res;
    swm_pkg::out_t want;
    if (!rst_n) begin
      win_fill = 0;
      win_wr = 0;
      win_len = 6'd1;
    end else begin
      if (cfg_valid && cfg_ready) win_len = cfg_data;
      if (in_valid && !in_stall) begin
        calc_window_min(in_data, made, res);
        if (pin_on) begin
          made = pin_made;
          res = pin_res;
        end
        if (made) min_q.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (min_q.size() == 0) begin
          $error("unexpected result: window_min %0d last_result %0b",
                 out_data.window_min, out_data.last_result);
          fail_cnt++;
        end else begin
          want = min_q.pop_front();
          if (out_data.window_min !== want.window_min) begin
            $error("window_min: expected %0d, actual %0d", want.window_min,
                   out_data.window_min);
            fail_cnt++;
          end
          if (out_data.last_result !== want.last_result) begin
            $error("last_result: expected %0b, actual %0b", want.last_result,
                   out_data.last_result);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: stall_lvl = 1'b0;
      1: stall_lvl = ($urandom_range(0, 3) == 0);
      2: stall_lvl = ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 30);
          run_lvl = !run_lvl;
        end
        run_left--;
        stall_lvl = run_lvl;
      end
    endcase
    out_stall <= stall_lvl;
  end

  // offer one transaction and hold it until taken; returns at a falling edge
  task automatic send_sample(input swm_pkg::in_t it, input bit pinned, input bit pmade,
                             input swm_pkg::out_t pres);
    in_valid <= 1'b1;
    in_data <= it;
    pin_on = pinned;
    pin_made = pmade;
    pin_res = pres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (min_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_window(input logic [swm_pkg::CFG_W-1:0] wl);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= wl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int            win_plan [14];
    int            wl;
    int            k;
    int            n;
    int            ph;
    int            sent;
    int            seq_left;
    int            burst_left;
    int            gap;
    swm_pkg::in_t  item;
    swm_pkg::out_t pres;

    win_plan = '{1, 0, 32, 63, 2, 3, 33, 5, 8, 4, 31, 16, 1, 7};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        set_window(dir_rows[r].wlen);
      end else begin
        item.sample = dir_rows[r].smp;
        item.last_sample = dir_rows[r].lst;
        pres.window_min = dir_rows[r].pmin;
        pres.last_result = dir_rows[r].plast;
        send_sample(item, dir_rows[r].pin, dir_rows[r].pmade, pres);
      end
    end

    sent = 0;
    ph = 0;
    seq_left = 0;
    burst_left = 0;
    pres = '0;
    while (sent < RAND_ITEMS) begin
      if (ph < 14) wl = win_plan[ph];
      else if ($urandom_range(0, 9) < 7) wl = $urandom_range(1, 8);
      else wl = $urandom_range(0, 63);
      ph++;
      // sequences may run on across a window change
      set_window(wl[swm_pkg::CFG_W-1:0]);
      k = (wl > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : wl;
      if (k == 0) k = 1;
      n = (wl >= 16) ? 40 : 70;
      repeat (n) begin
        if (seq_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2:    seq_left = $urandom_range(1, k);
            3, 4, 5, 6: seq_left = $urandom_range(k, k + 20);
            7:          seq_left = 1;
            default:    seq_left = $urandom_range(33, 70);
          endcase
        end
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0: item.sample = 32'sh80000000;
              1: item.sample = 32'sh7fffffff;
              2: item.sample = '0;
              default: item.sample = '1;
            endcase
          end
          1, 2, 3: item.sample = $signed($urandom_range(0, 8)) - 4;
          default: item.sample = $urandom;
        endcase
        item.last_sample = (seq_left == 1);
        seq_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        send_sample(item, 1'b0, 1'b0, pres);
        sent++;
        if (sent == RAND_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
hdl/swm_pkg.sv
hdl/sliding_window_minimum_core.sv
test/sliding_window_minimum_core_tb.sv
